/* hw/rtl/lsf_pkg.sv */
// ----------------------------------------------------------------------------
// Least-squares line fit package
// Widths, step codes, the controller/datapath command and status structs,
// and small helper functions shared by the line-fit modules.
// ----------------------------------------------------------------------------
package lsf_pkg;

    // Sample limit of one data set and the width of the sample counter.
    localparam int unsigned MAX_SAMPLES = 65536;
    localparam int unsigned CNT_W       = $clog2(MAX_SAMPLES + 1);

    // Input and accumulator widths.
    localparam int unsigned IN_W   = 16;
    localparam int unsigned SUM_W  = 32;
    localparam int unsigned SQ_W   = 47;
    // The signed cross sum needs one more bit, since a full set of the most
    // negative pair reaches exactly +2^46.
    localparam int unsigned XY_W   = SQ_W + 1;

    // Fit arithmetic widths.
    localparam int unsigned WIDE_W = 66;
    localparam int unsigned MAG_W  = 64;
    localparam int unsigned PROD_W = 2 * MAG_W;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned DVD_W  = PROD_W + FRAC_W;
    localparam int unsigned Q_W    = 32;
    localparam int unsigned R2_W   = 17;

    // Iteration counts of the shared multiplier and divider.
    localparam int unsigned MUL_STEPS = MAG_W;
    localparam int unsigned DIV_STEPS = DVD_W;
    localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    // Quotient limits.
    localparam logic [Q_W-1:0] CAP_POS = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] CAP_NEG = 32'h8000_0000;
    localparam logic [Q_W-1:0] CAP_R2  = 32'd65536;

    // Fit sequence steps.
    localparam int unsigned STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_N_SXY  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_SX_SY  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_N_SXX  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_SX_SX  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_N_SYY  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_SY_SY  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_GRAD   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_G_SX   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_ICPT   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_NN     = 4'd9;
    localparam logic [STEP_W-1:0] STEP_DXDY   = 4'd10;
    localparam logic [STEP_W-1:0] STEP_R2     = 4'd11;

    typedef struct packed {
        logic              accum;
        logic              clear;
        logic              mul_go;
        logic              div_go;
        logic              load;
        logic [STEP_W-1:0] sel;
    } t_cmd;

    typedef struct packed {
        logic mul_busy;
        logic div_busy;
        logic degenerate;
    } t_stat;

    function automatic logic step_is_div(input logic [STEP_W-1:0] s);
        return (s == STEP_GRAD) || (s == STEP_ICPT) || (s == STEP_R2);
    endfunction

    function automatic logic [MAG_W-1:0] mag66(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] a;
        a = v[WIDE_W-1] ? -v : v;
        return a[MAG_W-1:0];
    endfunction

endpackage

/* hw/rtl/lsf_mul.sv */
// ----------------------------------------------------------------------------
// Shift-add multiplier
// Unsigned 64 x 64 multiply, one multiplier bit per cycle, with a sign tag.
// ----------------------------------------------------------------------------
module lsf_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    input  logic [lsf_pkg::MAG_W-1:0]  i_a,
    input  logic [lsf_pkg::MAG_W-1:0]  i_b,
    input  logic                       i_neg,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [lsf_pkg::PROD_W-1:0] o_mag,
    output logic                       o_neg
);

    logic                          r_busy;
    logic                          r_done;
    logic [lsf_pkg::MUL_CNT_W-1:0] r_cnt;
    logic [lsf_pkg::MAG_W-1:0]     r_a;
    logic [lsf_pkg::MAG_W-1:0]     r_b;
    logic [lsf_pkg::PROD_W-1:0]    r_acc;
    logic                          r_neg;
    logic [lsf_pkg::MAG_W:0]       w_sum;
    logic [lsf_pkg::PROD_W-1:0]    n_acc;

    // Add the multiplicand into the upper half, then shift the product right.
    always_comb begin
        w_sum = {1'b0, r_acc[lsf_pkg::PROD_W-1:lsf_pkg::MAG_W]}
              + (r_b[0] ? {1'b0, r_a} : '0);
        n_acc = {w_sum, r_acc[lsf_pkg::MAG_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_neg  <= i_neg;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == lsf_pkg::MUL_CNT_W'(lsf_pkg::MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_mag  = r_acc;
    assign o_neg  = r_neg;

endmodule

/* hw/rtl/lsf_div.sv */
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned long division, one quotient bit per cycle, saturated to a limit.
// ----------------------------------------------------------------------------
module lsf_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    input  logic [lsf_pkg::DVD_W-1:0]  i_dividend,
    input  logic [lsf_pkg::PROD_W-1:0] i_divisor,
    input  logic [lsf_pkg::Q_W-1:0]    i_cap,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [lsf_pkg::Q_W-1:0]    o_quo
);

    logic                          r_busy;
    logic                          r_done;
    logic [lsf_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [lsf_pkg::DVD_W-1:0]     r_a;
    logic [lsf_pkg::PROD_W-1:0]    r_d;
    logic [lsf_pkg::PROD_W-1:0]    r_rem;
    logic [lsf_pkg::Q_W:0]         r_q;
    logic                          r_over;
    logic [lsf_pkg::Q_W-1:0]       r_cap;
    logic [lsf_pkg::PROD_W:0]      w_rem_sh;
    logic [lsf_pkg::PROD_W:0]      w_diff;
    logic                          w_ge;
    logic [lsf_pkg::PROD_W-1:0]    n_rem;

    always_comb begin
        w_rem_sh = {r_rem, r_a[lsf_pkg::DVD_W-1]};
        w_diff   = w_rem_sh - {1'b0, r_d};
        w_ge     = (w_rem_sh >= {1'b0, r_d});
        n_rem    = w_ge ? w_diff[lsf_pkg::PROD_W-1:0] : w_rem_sh[lsf_pkg::PROD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_dividend;
                r_d    <= i_divisor;
                r_cap  <= i_cap;
                r_rem  <= '0;
                r_q    <= '0;
                r_over <= 1'b0;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_a    <= r_a << 1;
                r_q    <= {r_q[lsf_pkg::Q_W-1:0], w_ge};
                r_over <= r_over | r_q[lsf_pkg::Q_W];
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == lsf_pkg::DIV_CNT_W'(lsf_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Once the quotient has passed the limit it stays there.
    assign o_quo  = (r_over || (r_q > {1'b0, r_cap})) ? r_cap : r_q[lsf_pkg::Q_W-1:0];
    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

/* hw/rtl/lsf_datapath.sv */
// ----------------------------------------------------------------------------
// Line-fit datapath
// Accumulators, intermediate fit terms, shared multiplier and divider,
// and the output payload register.
// ----------------------------------------------------------------------------
module lsf_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lsf_pkg::t_cmd                  i_cmd,
    output lsf_pkg::t_stat                 o_stat,
    input  logic signed [lsf_pkg::IN_W-1:0] i_x_value,
    input  logic signed [lsf_pkg::IN_W-1:0] i_y_value,
    output logic signed [31:0]             o_gradient,
    output logic signed [31:0]             o_intercept,
    output logic [lsf_pkg::R2_W-1:0]       o_r_squared,
    output logic                           o_degenerate
);

    localparam int unsigned WW = lsf_pkg::WIDE_W;

    logic [lsf_pkg::CNT_W-1:0]        r_count;
    logic signed [lsf_pkg::SUM_W-1:0] r_sum_x;
    logic signed [lsf_pkg::SUM_W-1:0] r_sum_y;
    logic signed [lsf_pkg::XY_W-1:0]  r_sum_xy;
    logic [lsf_pkg::SQ_W-1:0]         r_sum_xx;
    logic [lsf_pkg::SQ_W-1:0]         r_sum_yy;

    logic signed [2*lsf_pkg::IN_W-1:0] w_xy;
    logic signed [2*lsf_pkg::IN_W-1:0] w_xx;
    logic signed [2*lsf_pkg::IN_W-1:0] w_yy;

    logic [lsf_pkg::STEP_W-1:0]  r_sel;
    logic signed [WW-1:0]        r_p0;
    logic signed [WW-1:0]        r_num;
    logic signed [WW-1:0]        r_dx;
    logic signed [WW-1:0]        r_dy;
    logic signed [WW-1:0]        r_t;
    logic signed [31:0]          r_grad;
    logic signed [31:0]          r_icpt;
    logic [lsf_pkg::PROD_W-1:0]  r_top;
    logic [lsf_pkg::PROD_W-1:0]  r_bot;
    logic [lsf_pkg::R2_W-1:0]    r_r2;

    logic signed [31:0]          r_o_grad;
    logic signed [31:0]          r_o_icpt;
    logic [lsf_pkg::R2_W-1:0]    r_o_r2;
    logic                        r_o_degen;

    logic signed [WW-1:0]        w_sx;
    logic signed [WW-1:0]        w_sy;
    logic signed [WW-1:0]        w_sxy;
    logic signed [WW-1:0]        w_g;
    logic [lsf_pkg::MAG_W-1:0]   w_n_mag;
    logic [lsf_pkg::MAG_W-1:0]   w_num_mag;
    logic [lsf_pkg::MAG_W-1:0]   w_t_mag;

    logic [lsf_pkg::MAG_W-1:0]   w_mul_a;
    logic [lsf_pkg::MAG_W-1:0]   w_mul_b;
    logic                        w_mul_neg;
    logic                        w_mul_busy;
    logic                        w_mul_done;
    logic [lsf_pkg::PROD_W-1:0]  w_mul_mag;
    logic                        w_mul_sign;
    logic signed [WW-1:0]        w_prod;

    logic [lsf_pkg::DVD_W-1:0]   w_dvd;
    logic [lsf_pkg::PROD_W-1:0]  w_dvs;
    logic [lsf_pkg::Q_W-1:0]     w_cap;
    logic                        w_div_busy;
    logic                        w_div_done;
    logic [lsf_pkg::Q_W-1:0]     w_quo;
    logic                        w_degen;

    // ---------------- accumulation ----------------
    assign w_xy = i_x_value * i_y_value;
    assign w_xx = i_x_value * i_x_value;
    assign w_yy = i_y_value * i_y_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_count  <= '0;
            r_sum_x  <= '0;
            r_sum_y  <= '0;
            r_sum_xy <= '0;
            r_sum_xx <= '0;
            r_sum_yy <= '0;
        end else if (i_cmd.accum
                     && (r_count < lsf_pkg::CNT_W'(lsf_pkg::MAX_SAMPLES))) begin
            r_count  <= r_count + 1'b1;
            r_sum_x  <= r_sum_x + {{(lsf_pkg::SUM_W - lsf_pkg::IN_W){i_x_value[15]}},
                                   i_x_value};
            r_sum_y  <= r_sum_y + {{(lsf_pkg::SUM_W - lsf_pkg::IN_W){i_y_value[15]}},
                                   i_y_value};
            r_sum_xy <= r_sum_xy + {{(lsf_pkg::XY_W - 32){w_xy[31]}}, w_xy};
            r_sum_xx <= r_sum_xx + {{(lsf_pkg::SQ_W - 31){1'b0}}, w_xx[30:0]};
            r_sum_yy <= r_sum_yy + {{(lsf_pkg::SQ_W - 31){1'b0}}, w_yy[30:0]};
        end
    end

    // ---------------- operand selection ----------------
    assign w_sx  = {{(WW - lsf_pkg::SUM_W){r_sum_x[lsf_pkg::SUM_W-1]}}, r_sum_x};
    assign w_sy  = {{(WW - lsf_pkg::SUM_W){r_sum_y[lsf_pkg::SUM_W-1]}}, r_sum_y};
    assign w_sxy = {{(WW - lsf_pkg::XY_W){r_sum_xy[lsf_pkg::XY_W-1]}}, r_sum_xy};
    assign w_g   = {{(WW - 32){r_grad[31]}}, r_grad};
    assign w_n_mag   = {{(lsf_pkg::MAG_W - lsf_pkg::CNT_W){1'b0}}, r_count};
    assign w_num_mag = lsf_pkg::mag66(r_num);
    assign w_t_mag   = lsf_pkg::mag66(r_t);

    always_comb begin
        w_mul_a   = '0;
        w_mul_b   = '0;
        w_mul_neg = 1'b0;
        unique case (i_cmd.sel)
            lsf_pkg::STEP_N_SXY: begin
                w_mul_a   = w_n_mag;
                w_mul_b   = lsf_pkg::mag66(w_sxy);
                w_mul_neg = r_sum_xy[lsf_pkg::XY_W-1];
            end
            lsf_pkg::STEP_SX_SY: begin
                w_mul_a   = lsf_pkg::mag66(w_sx);
                w_mul_b   = lsf_pkg::mag66(w_sy);
                w_mul_neg = r_sum_x[lsf_pkg::SUM_W-1] ^ r_sum_y[lsf_pkg::SUM_W-1];
            end
            lsf_pkg::STEP_N_SXX: begin
                w_mul_a = w_n_mag;
                w_mul_b = {{(lsf_pkg::MAG_W - lsf_pkg::SQ_W){1'b0}}, r_sum_xx};
            end
            lsf_pkg::STEP_SX_SX: begin
                w_mul_a = lsf_pkg::mag66(w_sx);
                w_mul_b = lsf_pkg::mag66(w_sx);
            end
            lsf_pkg::STEP_N_SYY: begin
                w_mul_a = w_n_mag;
                w_mul_b = {{(lsf_pkg::MAG_W - lsf_pkg::SQ_W){1'b0}}, r_sum_yy};
            end
            lsf_pkg::STEP_SY_SY: begin
                w_mul_a = lsf_pkg::mag66(w_sy);
                w_mul_b = lsf_pkg::mag66(w_sy);
            end
            lsf_pkg::STEP_G_SX: begin
                w_mul_a   = lsf_pkg::mag66(w_g);
                w_mul_b   = lsf_pkg::mag66(w_sx);
                w_mul_neg = r_grad[31] ^ r_sum_x[lsf_pkg::SUM_W-1];
            end
            lsf_pkg::STEP_NN: begin
                w_mul_a = w_num_mag;
                w_mul_b = w_num_mag;
            end
            lsf_pkg::STEP_DXDY: begin
                w_mul_a = r_dx[lsf_pkg::MAG_W-1:0];
                w_mul_b = r_dy[lsf_pkg::MAG_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_dvd = '0;
        w_dvs = '0;
        w_cap = lsf_pkg::CAP_POS;
        unique case (i_cmd.sel)
            lsf_pkg::STEP_GRAD: begin
                w_dvd = {{(lsf_pkg::DVD_W - lsf_pkg::MAG_W - lsf_pkg::FRAC_W){1'b0}},
                         w_num_mag, {lsf_pkg::FRAC_W{1'b0}}};
                w_dvs = {{(lsf_pkg::PROD_W - lsf_pkg::MAG_W){1'b0}},
                         r_dx[lsf_pkg::MAG_W-1:0]};
                w_cap = r_num[WW-1] ? lsf_pkg::CAP_NEG : lsf_pkg::CAP_POS;
            end
            lsf_pkg::STEP_ICPT: begin
                w_dvd = {{(lsf_pkg::DVD_W - lsf_pkg::MAG_W){1'b0}}, w_t_mag};
                w_dvs = {{(lsf_pkg::PROD_W - lsf_pkg::CNT_W - 8){1'b0}}, r_count, 8'b0};
                w_cap = r_t[WW-1] ? lsf_pkg::CAP_NEG : lsf_pkg::CAP_POS;
            end
            lsf_pkg::STEP_R2: begin
                w_dvd = {r_top, {lsf_pkg::FRAC_W{1'b0}}};
                w_dvs = r_bot;
                w_cap = lsf_pkg::CAP_R2;
            end
            default: begin
            end
        endcase
    end

    lsf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.mul_go),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .i_neg   (w_mul_neg),
        .o_busy  (w_mul_busy),
        .o_done  (w_mul_done),
        .o_mag   (w_mul_mag),
        .o_neg   (w_mul_sign)
    );

    lsf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (i_cmd.div_go),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .i_cap      (w_cap),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quo      (w_quo)
    );

    // Every signed product of the first phase fits well inside the wide word.
    assign w_prod = w_mul_sign
                  ? (WW'(0) - {2'b0, w_mul_mag[lsf_pkg::MAG_W-1:0]})
                  : {2'b0, w_mul_mag[lsf_pkg::MAG_W-1:0]};

    // ---------------- result capture ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_go || i_cmd.div_go) begin
            r_sel <= i_cmd.sel;
        end
        if (w_mul_done) begin
            unique case (r_sel)
                lsf_pkg::STEP_N_SXY,
                lsf_pkg::STEP_N_SXX,
                lsf_pkg::STEP_N_SYY: r_p0  <= w_prod;
                lsf_pkg::STEP_SX_SY: r_num <= r_p0 - w_prod;
                lsf_pkg::STEP_SX_SX: r_dx  <= r_p0 - w_prod;
                lsf_pkg::STEP_SY_SY: r_dy  <= r_p0 - w_prod;
                lsf_pkg::STEP_G_SX:  r_t   <= {w_sy[WW-17:0], 16'b0} - w_prod;
                lsf_pkg::STEP_NN:    r_top <= w_mul_mag;
                lsf_pkg::STEP_DXDY:  r_bot <= w_mul_mag;
                default: begin
                end
            endcase
        end
        if (w_div_done) begin
            unique case (r_sel)
                lsf_pkg::STEP_GRAD: r_grad <= r_num[WW-1] ? (32'sd0 - $signed(w_quo))
                                                          : $signed(w_quo);
                lsf_pkg::STEP_ICPT: r_icpt <= r_t[WW-1] ? (32'sd0 - $signed(w_quo))
                                                        : $signed(w_quo);
                lsf_pkg::STEP_R2:   r_r2   <= w_quo[lsf_pkg::R2_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_degen = (r_dx <= 0) || (r_dy <= 0);

    // ---------------- output payload ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_grad  <= w_degen ? '0 : r_grad;
            r_o_icpt  <= w_degen ? '0 : r_icpt;
            r_o_r2    <= w_degen ? '0 : r_r2;
            r_o_degen <= w_degen;
        end
    end

    assign o_gradient   = r_o_grad;
    assign o_intercept  = r_o_icpt;
    assign o_r_squared  = r_o_r2;
    assign o_degenerate = r_o_degen;

    assign o_stat.mul_busy   = w_mul_busy | w_mul_done;
    assign o_stat.div_busy   = w_div_busy | w_div_done;
    assign o_stat.degenerate = w_degen;

    // ---------------- assertions ----------------
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_stat.mul_busy && o_stat.div_busy))
        else $error("multiplier and divider active together");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lsf_pkg::CNT_W'(lsf_pkg::MAX_SAMPLES))
        else $error("sample count beyond limit");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load && w_degen |=> (o_gradient == 0) && (o_intercept == 0)
                                  && (o_r_squared == 0) && o_degenerate)
        else $error("degenerate fit without zero results");

endmodule

/* hw/rtl/lsf_ctrl.sv */
// ----------------------------------------------------------------------------
// Line-fit controller
// Handshakes both channels and steps the datapath through the fit sequence.
// ----------------------------------------------------------------------------
module lsf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_last_sample,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    output lsf_pkg::t_cmd  o_cmd,
    input  lsf_pkg::t_stat i_stat
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ISSUE  = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]                  r_state;
    logic [1:0]                  n_state;
    logic [lsf_pkg::STEP_W-1:0]  r_step;
    logic [lsf_pkg::STEP_W-1:0]  n_step;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic                        w_accept;

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        o_cmd     = '0;
        o_cmd.sel = r_step;
        w_accept  = (r_state == ST_IDLE) && i_valid;
        o_cmd.accum = w_accept;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && i_last_sample) begin
                    n_state = ST_ISSUE;
                    n_step  = lsf_pkg::STEP_N_SXY;
                end
            end
            ST_ISSUE: begin
                o_cmd.mul_go = !lsf_pkg::step_is_div(r_step);
                o_cmd.div_go = lsf_pkg::step_is_div(r_step);
                n_state      = ST_WAIT;
            end
            ST_WAIT: begin
                if (!(i_stat.mul_busy || i_stat.div_busy)) begin
                    if ((r_step == lsf_pkg::STEP_R2)
                        || ((r_step == lsf_pkg::STEP_SY_SY) && i_stat.degenerate)) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_step  = r_step + 1'b1;
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.load  = 1'b1;
                    o_cmd.clear = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = o_cmd.load | (r_out_valid & i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= lsf_pkg::STEP_N_SXY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

    a_mul_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mul_go |=> i_stat.mul_busy)
        else $error("multiplier did not start");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_go |=> i_stat.div_busy)
        else $error("divider did not start");

    a_load_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_valid)
        else $error("result load did not raise output valid");

endmodule

/* hw/rtl/least_squares_line_fit.sv */
// ----------------------------------------------------------------------------
// Least-squares line fit
// Streams signed Q8.8 (x, y) pairs, and on the last pair of a data set
// produces gradient, intercept (Q16.16, saturated) and r squared (Q1.16).
// ----------------------------------------------------------------------------
// Samples are taken one per clock while the block is collecting: each
// transfer on the input channel adds the pair to the count and to the exact
// sums of x, y, xy, xx and yy (pairs after the 65536th are ignored). The
// transfer that carries last_sample starts the fit, and o_stall stays high
// until the fit's result is loaded into the output register. The fit runs
// on one shared shift-add multiplier and one shared restoring divider:
// nine products and three quotients. A degenerate set, where the x or y
// variance is zero, stops after the first six products and reports zeros
// with degenerate set. The result sits in an output register, so
// collecting the next data set can start while the result still waits for
// its transfer; only the end of a second fit then waits for the first
// result to leave.
// ----------------------------------------------------------------------------
module least_squares_line_fit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_x_value,
    input  logic signed [15:0] i_y_value,
    input  logic               i_last_sample,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_gradient,
    output logic signed [31:0] o_intercept,
    output logic [16:0]        o_r_squared,
    output logic               o_degenerate
);

    // Commands from the sequencer and status back from the arithmetic.
    lsf_pkg::t_cmd  w_cmd;
    lsf_pkg::t_stat w_stat;

    lsf_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_last_sample (i_last_sample),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_cmd         (w_cmd),
        .i_stat        (w_stat)
    );

    lsf_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_x_value    (i_x_value),
        .i_y_value    (i_y_value),
        .o_gradient   (o_gradient),
        .o_intercept  (o_intercept),
        .o_r_squared  (o_r_squared),
        .o_degenerate (o_degenerate)
    );

endmodule

/* tb/tb_least_squares_line_fit.sv */
// ----------------------------------------------------------------------------
// Least-squares line fit testbench
// Streams data sets of signed Q8.8 pairs into the block, predicts gradient,
// intercept, r squared and the degenerate flag for every set in wide integer
// arithmetic, and checks each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_least_squares_line_fit;

    typedef struct {
        logic signed [31:0] grad;
        logic signed [31:0] icpt;
        logic [16:0]        r2;
        logic               degen;
    } fit_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_x_value;
    logic signed [15:0] i_y_value;
    logic               i_last_sample;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_gradient;
    logic signed [31:0] o_intercept;
    logic [16:0]        o_r_squared;
    logic               o_degenerate;

    least_squares_line_fit dut (.*);

    // The clock runs with a period of 20 time units.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Running sums of the open data set, held wide enough to stay exact.
    logic [16:0]         set_count;
    logic signed [63:0]  set_sx, set_sy, set_sxy, set_sxx, set_syy;
    fit_t                fit_queue[$];
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  mismatches = 0;
    int                  fits_checked = 0;
    int                  pairs_sent;
    int                  quiet_cycles = 0;

    // Computes the expected fit over the open set and then clears the set.
    function automatic fit_t predict_fit();
        fit_t                f;
        logic signed [127:0] n, num, dx, dy, g, t, icpt, q;
        logic [255:0]        top, bot, r2;
        n   = set_count;
        num = n * set_sxy - set_sx * set_sy;
        dx  = n * set_sxx - set_sx * set_sx;
        dy  = n * set_syy - set_sy * set_sy;
        f   = '{0, 0, 0, 1'b0};
        if (dx <= 0 || dy <= 0) begin
            f.degen = 1'b1;
        end else begin
            // Quotient of magnitudes truncates toward zero, then saturates.
            if (num < 0) begin
                q = ((-num) <<< 16) / dx;
                g = (q > 128'sd2147483648) ? -128'sd2147483648 : -q;
            end else begin
                q = (num <<< 16) / dx;
                g = (q > 128'sd2147483647) ? 128'sd2147483647 : q;
            end
            t    = set_sy * 65536 - g * set_sx;
            icpt = t / (n * 256);
            if (icpt > 128'sd2147483647) icpt = 128'sd2147483647;
            if (icpt < -128'sd2147483648) icpt = -128'sd2147483648;
            top = num * num;
            bot = dx * dy;
            r2  = (top << 16) / bot;
            if (r2 > 65536) r2 = 65536;
            f.grad = g[31:0];
            f.icpt = icpt[31:0];
            f.r2   = r2[16:0];
        end
        set_count = 0;
        set_sx = 0; set_sy = 0; set_sxy = 0; set_sxx = 0; set_syy = 0;
        return f;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        $display("tb: mismatch on %s: got %0d, expected %0d", what, got, exp);
        mismatches++;
    endtask

    // Sends one pair; the prediction is made once the transfer has happened.
    // Valid stays high after the transfer so pairs can follow back to back;
    // it drops in an idle cycle or when the sender stops.
    task automatic send_pair(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_x_value     <= x;
        i_y_value     <= y;
        i_last_sample <= last;
        do @(posedge i_clk); while (o_stall);
        pairs_sent++;
        if (set_count < 65536) begin
            set_count++;
            set_sx  += x;
            set_sy  += y;
            set_sxy += x * y;
            set_sxx += x * x;
            set_syy += y * y;
        end
        if (last) fit_queue.insert(fit_queue.size(), predict_fit());
        @(negedge i_clk);
    endtask

    // Random receiver stall, changed at the falling edge.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Result checker, sampling at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (fit_queue.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                fit_t e;
                e = fit_queue.pop_front();
                fits_checked++;
                if (o_gradient !== e.grad)    report_mismatch("gradient", o_gradient, e.grad);
                if (o_intercept !== e.icpt)   report_mismatch("intercept", o_intercept, e.icpt);
                if (o_r_squared !== e.r2)     report_mismatch("r_squared", o_r_squared, e.r2);
                if (o_degenerate !== e.degen) report_mismatch("degenerate", o_degenerate, e.degen);
            end
        end
    end

    // Watchdog: a long stretch without any transfer on either channel means
    // the block has hung.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (fit_queue.size() != 0) @(negedge i_clk);
    endtask

    // Sends one data set of the given length with random content.
    task automatic send_random_set(input int len);
        for (int k = 0; k < len; k++)
            send_pair(16'($urandom), 16'($urandom), k == len - 1);
    endtask

    // A set built on a noisy straight line, so fits land in a sensible range.
    task automatic send_line_set(input int len);
        int slope, base, noise;
        slope = $urandom_range(8, 0) - 4;
        base  = $urandom_range(4000, 0) - 2000;
        noise = $urandom_range(600, 0);
        for (int k = 0; k < len; k++) begin
            int x, y;
            x = $urandom_range(8000, 0) - 4000;
            y = base + slope * x + $urandom_range(2 * noise, 0) - noise;
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            send_pair(16'(x), 16'(y), k == len - 1);
        end
    endtask

    task automatic test_extremes();
        send_pair(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_pair(-16'sh8000, -16'sh8000, 1'b1);
        send_pair(-16'sh8000, 16'sh7FFF, 1'b0);
        send_pair(16'sh7FFF, -16'sh8000, 1'b1);
        send_pair(16'sh0000, 16'sh7FFF, 1'b0);
        send_pair(16'sh0001, -16'sh8000, 1'b1);
        // Steep gradient saturates positive and negative.
        send_pair(16'sh0000, -16'sh8000, 1'b0);
        send_pair(16'sh0001, 16'sh7FFF, 1'b1);
        send_pair(16'sh0000, 16'sh7FFF, 1'b0);
        send_pair(16'sh0001, -16'sh8000, 1'b1);
    endtask

    task automatic test_degenerate();
        // A set of one pair, constant x, and constant y.
        send_pair(16'sh1234, -16'sh0567, 1'b1);
        send_pair(16'sh0100, 16'sh0001, 1'b0);
        send_pair(16'sh0100, 16'sh0200, 1'b1);
        send_pair(16'sh0003, 16'sh0400, 1'b0);
        send_pair(-16'sh0300, 16'sh0400, 1'b1);
        // Perfect line gives r squared of one.
        send_pair(16'sh0100, 16'sh0300, 1'b0);
        send_pair(16'sh0200, 16'sh0500, 1'b0);
        send_pair(16'sh0300, 16'sh0700, 1'b1);
    endtask

    task automatic test_random(input int pairs);
        int sent0;
        sent0 = pairs_sent;
        while (pairs_sent - sent0 < pairs) begin
            case ($urandom_range(9))
                0, 1:    send_random_set($urandom_range(6, 1));
                2:       send_random_set($urandom_range(40, 2));
                default: send_line_set($urandom_range(30, 2));
            endcase
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_x_value = '0;
        i_y_value = '0;
        i_last_sample = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        pairs_sent = 0;
        set_count = 0;
        set_sx = 0; set_sy = 0; set_sxy = 0; set_sxx = 0; set_syy = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_extremes();
        test_degenerate();
        test_random(450);
        // Hold the sender until every pending fit has been taken.
        wait_drained();
        send_idle_pct = 72;
        test_random(450);
        send_idle_pct = 0;
        recv_stall_pct = 72;
        test_random(450);
        send_idle_pct = 17;
        recv_stall_pct = 17;
        test_random(450);
        send_idle_pct = 0;
        recv_stall_pct = 0;

        wait_drained();
        repeat (2000) @(negedge i_clk);
        $display("tb: %0d pairs sent, %0d fits checked, including saturation,",
                 pairs_sent, fits_checked);
        $display("tb: zero variance sets and several idle and stall mixes");
        if (mismatches == 0 && fit_queue.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
